// File: rtl/core/tfm_pkg.sv
package tfm_pkg;

  // Pattern store depth and derived widths
  localparam int PATTERN_BYTES = 256;
  localparam int PAT_AW        = $clog2(PATTERN_BYTES);
  localparam int PAT_LW        = $clog2(PATTERN_BYTES + 1);

  // Special filter characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // One write into the pattern store
  typedef struct packed {
    logic              en;
    logic [PAT_AW-1:0] addr;
    logic [7:0]        data;
  } tfm_wr_t;

endpackage

// File: rtl/core/tfm_pattern_ram.sv
module tfm_pattern_ram (
  input  logic                      clk_i,
  input  tfm_pkg::tfm_wr_t          wr_i,
  input  logic [tfm_pkg::PAT_AW-1:0] raddr0_i,
  input  logic [tfm_pkg::PAT_AW-1:0] raddr1_i,
  output logic [7:0]                rdata0_o,
  output logic [7:0]                rdata1_o
);
  import tfm_pkg::*;

  logic [7:0] mem [PATTERN_BYTES];
  logic [7:0] rdata0_q;
  logic [7:0] rdata1_q;

  // Write one byte, read two; a same-cycle write to a read address is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata0_q <= (wr_i.en && (wr_i.addr == raddr0_i)) ? wr_i.data : mem[raddr0_i];
    rdata1_q <= (wr_i.en && (wr_i.addr == raddr1_i)) ? wr_i.data : mem[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: rtl/core/topic_filter_matcher.sv
// The match bit is registered in the output register. Throughput: one pattern or
// topic byte per cycle while the output skid entry is empty, set by a
// four-byte pattern window read from two copies of the pattern RAM (two ports each).
// Reset: empty pattern, pointer at zero; the pattern RAM is not cleared and needs no
// clearing pass, so the block takes bytes right after reset.
module topic_filter_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tuser_i,  // [0] opcode
  input  logic       s_axis_tlast_i,  // last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] match, [7:1] zero
);
  import tfm_pkg::*;

  localparam logic [1:0] PH_COMPARE = 2'd0;
  localparam logic [1:0] PH_SKIP    = 2'd1;
  localparam logic [1:0] PH_ACCEPT  = 2'd2;
  localparam logic [1:0] PH_FAIL    = 2'd3;

  logic [PAT_LW-1:0] len_q, len_d;
  logic [PAT_LW-1:0] pos_q, pos_d;
  logic              complete_q, complete_d;
  logic [1:0]        phase_q, phase_d;

  logic [7:0]        win0, win1, win2, win3;
  logic [PAT_LW-1:0] pa1, pa2, pa3;
  tfm_wr_t           wr;

  logic              accept, pat_acc, top_acc, push, pop;
  logic [PAT_LW-1:0] rem, rem_new;
  logic [1:0]        adv;
  logic [1:0]        phase_new;
  logic [7:0]        e0, e1;
  logic              end_ok, res_bit;

  logic              out_valid_q, skid_valid_q;
  logic              out_q, skid_q;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign pat_acc = accept && !s_axis_tuser_i;
  assign top_acc = accept && s_axis_tuser_i;
  assign push    = top_acc && s_axis_tlast_i;
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;

  // Pattern window: bytes at pos, pos+1 (copy A) and pos+2, pos+3 (copy B)
  assign pa1 = pos_d + PAT_LW'(1);
  assign pa2 = pos_d + PAT_LW'(2);
  assign pa3 = pos_d + PAT_LW'(3);

  tfm_pattern_ram u_ram_a (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .raddr0_i (pos_d[PAT_AW-1:0]),
    .raddr1_i (pa1[PAT_AW-1:0]),
    .rdata0_o (win0),
    .rdata1_o (win1)
  );

  tfm_pattern_ram u_ram_b (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .raddr0_i (pa2[PAT_AW-1:0]),
    .raddr1_i (pa3[PAT_AW-1:0]),
    .rdata0_o (win2),
    .rdata1_o (win3)
  );

  // Step the matcher by one topic byte and evaluate the end check
  always_comb begin
    rem       = len_q - pos_q;
    adv       = 2'd0;
    phase_new = phase_q;
    case (phase_q)
      PH_SKIP: begin
        if (s_axis_tdata_i == CH_SLASH) phase_new = PH_COMPARE;
      end
      PH_COMPARE: begin
        if (rem == '0) begin
          phase_new = PH_FAIL;
        end else if (win0 == CH_HASH) begin
          phase_new = PH_ACCEPT;
        end else if (win0 == CH_PLUS) begin
          adv       = ((rem > PAT_LW'(1)) && (win1 == CH_SLASH)) ? 2'd2 : 2'd1;
          phase_new = (s_axis_tdata_i == CH_SLASH) ? PH_COMPARE : PH_SKIP;
        end else if (win0 != s_axis_tdata_i) begin
          phase_new = PH_FAIL;
        end else begin
          adv = 2'd1;
        end
      end
      default: ;
    endcase

    rem_new = rem - PAT_LW'(adv);
    case (adv)
      2'd0: begin
        e0 = win0;
        e1 = win1;
      end
      2'd1: begin
        e0 = win1;
        e1 = win2;
      end
      default: begin
        e0 = win2;
        e1 = win3;
      end
    endcase

    // Exhausted pattern, a hash, or exactly "/#" left
    end_ok  = (rem_new == '0) || (e0 == CH_HASH) ||
              ((rem_new == PAT_LW'(2)) && (e0 == CH_SLASH) && (e1 == CH_HASH));
    res_bit = (phase_new == PH_ACCEPT) || ((phase_new != PH_FAIL) && end_ok);
  end

  // Next state for pattern loading and topic matching
  always_comb begin
    len_d      = len_q;
    pos_d      = pos_q;
    complete_d = complete_q;
    phase_d    = phase_q;
    wr.en      = 1'b0;
    wr.addr    = complete_q ? '0 : len_q[PAT_AW-1:0];
    wr.data    = s_axis_tdata_i;
    if (pat_acc) begin
      pos_d      = '0;
      phase_d    = PH_COMPARE;
      complete_d = s_axis_tlast_i;
      if (complete_q) begin
        wr.en = 1'b1;
        len_d = PAT_LW'(1);
      end else if (len_q < PAT_LW'(PATTERN_BYTES)) begin
        wr.en = 1'b1;
        len_d = len_q + PAT_LW'(1);
      end
    end else if (top_acc) begin
      if (s_axis_tlast_i) begin
        pos_d   = '0;
        phase_d = PH_COMPARE;
      end else begin
        pos_d   = pos_q + PAT_LW'(adv);
        phase_d = phase_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pos_q      <= '0;
      complete_q <= 1'b1;
      phase_q    <= PH_COMPARE;
    end else begin
      len_q      <= len_d;
      pos_q      <= pos_d;
      complete_q <= complete_d;
      phase_q    <= phase_d;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_q  <= skid_valid_q ? skid_q : res_bit;
      skid_q <= res_bit;
    end else if (push) begin
      skid_q <= res_bit;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q};

  // Pointer stays inside the stored pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= len_q)
    else $error("pattern pointer beyond pattern length");

  // Skid entry only fills behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // A pattern byte restarts the matcher
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_acc |=> (pos_q == '0) && (phase_q == PH_COMPARE))
    else $error("matcher not restarted after pattern byte");

  // A finished topic leaves the matcher at its start and posts a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (pos_q == '0) && (phase_q == PH_COMPARE) && out_valid_q)
    else $error("topic end did not restart matcher or post a result");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tfm_pkg::*;

  // Matcher progress through the topic in flight
  typedef enum logic [1:0] {
    MS_COMPARE,
    MS_SKIP,
    MS_ACCEPT,
    MS_REJECT
  } match_state_e;

  localparam bit OP_PATTERN = 1'b0;
  localparam bit OP_TOPIC   = 1'b1;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b1;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_tdata;

  topic_filter_matcher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i  (s_tuser),   // [0] opcode
    .s_axis_tlast_i  (s_tlast),   // last
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [0] match, [7:1] zero
  );

  // Shadow copy of the filter store and matcher state
  logic [7:0]   pat_mem [PATTERN_BYTES];
  int           pat_len;
  bit           pat_done;
  int           pat_ptr;
  match_state_e mstate;
  bit           topic_busy;

  logic [7:0] match_q [$];
  int         err_cnt;
  int         idle_pct;
  int         stall_pct;
  int         n_sent;
  string      flt_lv [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each match transfer with the oldest prediction
  always @(negedge clk_i) begin : match_check
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h", $time, m_tdata);
        err_cnt++;
      end else begin
        want = match_q.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: match mismatch, expected %02h, actual %02h", $time, want, m_tdata);
          err_cnt++;
        end
      end
    end
  end

  // Filter byte at index i, or -1 past the stored end
  function automatic int pat_byte(int i);
    if (i >= pat_len) return -1;
    return int'(pat_mem[i]);
  endfunction

  function automatic bit tail_accepts();
    int a;
    a = pat_byte(pat_ptr);
    if (a < 0) return 1'b1;
    if (a == int'(CH_HASH)) return 1'b1;
    if (pat_len - pat_ptr == 2 && a == int'(CH_SLASH) &&
        pat_byte(pat_ptr + 1) == int'(CH_HASH)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void advance_topic(logic [7:0] c);
    int q;
    if (mstate == MS_ACCEPT || mstate == MS_REJECT) return;
    if (mstate == MS_SKIP) begin
      if (c == CH_SLASH) mstate = MS_COMPARE;
      return;
    end
    q = pat_byte(pat_ptr);
    if (q < 0) begin
      mstate = MS_REJECT;
    end else if (q == int'(CH_HASH)) begin
      mstate = MS_ACCEPT;
    end else if (q == int'(CH_PLUS)) begin
      pat_ptr++;
      if (pat_byte(pat_ptr) == int'(CH_SLASH)) pat_ptr++;
      mstate = (c == CH_SLASH) ? MS_COMPARE : MS_SKIP;
    end else if (q != int'(c)) begin
      mstate = MS_REJECT;
    end else begin
      pat_ptr++;
    end
  endfunction

  // Update the shadow state for one accepted byte, queue any match bit
  function automatic void predict_byte(bit op, logic [7:0] c, bit lst);
    bit hit;
    if (op == OP_PATTERN) begin
      topic_busy = 1'b0;
      pat_ptr    = 0;
      mstate     = MS_COMPARE;
      if (pat_done) begin
        pat_len  = 0;
        pat_done = 1'b0;
      end
      if (pat_len < PATTERN_BYTES) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end
      if (lst) pat_done = 1'b1;
      return;
    end
    if (!topic_busy) begin
      pat_ptr    = 0;
      mstate     = MS_COMPARE;
      topic_busy = 1'b1;
    end
    advance_topic(c);
    if (!lst) return;
    if (mstate == MS_ACCEPT) hit = 1'b1;
    else if (mstate == MS_REJECT) hit = 1'b0;
    else hit = tail_accepts();
    match_q.push_back({7'd0, hit});
    topic_busy = 1'b0;
    pat_ptr    = 0;
    mstate     = MS_COMPARE;
  endfunction

  // Drive one byte; hold valid across back-to-back transfers
  task automatic send_byte(input bit op, input logic [7:0] d, input bit lst);
    bit took;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    s_tlast  <= lst;
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
    predict_byte(op, d, lst);
    n_sent++;
  endtask

  task automatic send_str(input bit op, input string s);
    for (int i = 0; i < s.len(); i++) send_byte(op, s[i], i == s.len() - 1);
  endtask

  function automatic string rand_word();
    case ($urandom_range(6))
      0: return "";
      1: return "a";
      2: return "b";
      3: return "ab";
      4: return "ba";
      5: return "c";
      default: return "abc";
    endcase
  endfunction

  // Build a random well-formed filter, keep its levels for topic generation
  function automatic string make_filter();
    string f;
    int    nlev;
    f = "";
    flt_lv.delete();
    nlev = $urandom_range(1, 4);
    for (int i = 0; i < nlev; i++) begin
      if (i == nlev - 1 && $urandom_range(4) == 0) flt_lv.push_back("#");
      else if ($urandom_range(3) == 0) flt_lv.push_back("+");
      else flt_lv.push_back(rand_word());
      f = (i == 0) ? flt_lv[i] : {f, "/", flt_lv[i]};
    end
    if (f.len() == 0) begin
      f = "a";
      flt_lv[0] = "a";
    end
    return f;
  endfunction

  // Topic that mostly follows the current filter, with occasional breaks
  function automatic string make_topic();
    string t;
    string lv;
    int    lim;
    int    n;
    t = "";
    lim = flt_lv.size();
    if ($urandom_range(9) == 0 && lim > 1) lim--;
    for (int i = 0; i < lim; i++) begin
      if (flt_lv[i] == "+") begin
        lv = rand_word();
      end else if (flt_lv[i] == "#") begin
        lv = rand_word();
        n = $urandom_range(2);
        repeat (n) lv = {lv, "/", rand_word()};
      end else begin
        lv = ($urandom_range(9) == 0) ? rand_word() : flt_lv[i];
      end
      t = (i == 0) ? lv : {t, "/", lv};
    end
    if ($urandom_range(9) == 0) t = {t, "/", rand_word()};
    if (t.len() == 0) t = "a";
    return t;
  endfunction

  task automatic test_empty_pattern();
    send_str(OP_TOPIC, "a");
    send_str(OP_TOPIC, "/");
  endtask

  task automatic test_plain_levels();
    send_str(OP_PATTERN, "a/b");
    send_str(OP_TOPIC, "a/b");
    send_str(OP_TOPIC, "a/c");
    send_str(OP_TOPIC, "a/b/c");
    send_str(OP_TOPIC, "a");
  endtask

  task automatic test_wildcards();
    send_str(OP_PATTERN, "+/#");
    send_str(OP_TOPIC, "x/y/z");
    send_str(OP_PATTERN, "a/#");
    send_str(OP_TOPIC, "a");
    send_str(OP_PATTERN, "#");
    send_str(OP_TOPIC, "q");
    send_str(OP_PATTERN, "+");
    send_str(OP_TOPIC, "/");
  endtask

  task automatic test_byte_extremes();
    send_byte(OP_PATTERN, 8'h00, 1'b0);
    send_byte(OP_PATTERN, 8'hFF, 1'b1);
    send_byte(OP_TOPIC, 8'h00, 1'b0);
    send_byte(OP_TOPIC, 8'hFF, 1'b1);
    send_byte(OP_TOPIC, 8'h00, 1'b0);
    send_byte(OP_TOPIC, 8'h7F, 1'b1);
  endtask

  // Pattern byte cuts a topic short; no result for the abandoned topic
  task automatic test_topic_abandoned();
    send_byte(OP_TOPIC, "a", 1'b0);
    send_byte(OP_PATTERN, "b", 1'b1);
    send_str(OP_TOPIC, "b");
  endtask

  // Topic matched against a partly loaded filter, then loading resumes
  task automatic test_topic_mid_load();
    send_byte(OP_PATTERN, "a", 1'b0);
    send_byte(OP_PATTERN, "b", 1'b0);
    send_str(OP_TOPIC, "ab");
    send_byte(OP_PATTERN, "c", 1'b1);
    send_str(OP_TOPIC, "abc");
  endtask

  // Overlong filter: bytes past the store depth are dropped
  task automatic test_truncation();
    for (int i = 0; i < PATTERN_BYTES + 3; i++)
      send_byte(OP_PATTERN, "a", i == PATTERN_BYTES + 2);
    for (int i = 0; i < PATTERN_BYTES; i++)
      send_byte(OP_TOPIC, "a", i == PATTERN_BYTES - 1);
    for (int i = 0; i < PATTERN_BYTES + 1; i++)
      send_byte(OP_TOPIC, "a", i == PATTERN_BYTES);
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    int target;
    int r;
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    target    = n_sent + n_items;
    send_str(OP_PATTERN, make_filter());
    while (n_sent < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        // noise: arbitrary opcode, byte and last flag
        n = $urandom_range(1, 4);
        repeat (n) send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
      end else if (r < 27) begin
        send_str(OP_PATTERN, make_filter());
      end else begin
        send_str(OP_TOPIC, make_topic());
      end
    end
  endtask

  initial begin
    pat_len    = 0;
    pat_done   = 1'b1;
    pat_ptr    = 0;
    mstate     = MS_COMPARE;
    topic_busy = 1'b0;
    err_cnt    = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    n_sent     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pattern();
    test_plain_levels();
    test_wildcards();
    test_byte_extremes();
    test_topic_abandoned();
    test_topic_mid_load();
    test_truncation();

    test_random(200, 0, 0);
    test_random(200, 64, 0);
    test_random(200, 0, 64);
    test_random(200, 34, 34);

    s_tvalid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
